FILE: rtl/substring_search_first_last_unit_defines.svh
// Assertion macros for the substring search unit.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef SUBSTRING_SEARCH_FIRST_LAST_UNIT_DEFINES_SVH
`define SUBSTRING_SEARCH_FIRST_LAST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ssfl_pkg.sv
// Shared types and constants for the substring search unit.
// No dependencies.
`default_nettype none

package ssfl_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int NEEDLE_BYTES = 16;   // bytes held by the two needle registers
    localparam int NLEN_W      = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LOW    = 2'd0,
        CFG_NEEDLE_HIGH   = 2'd1,
        CFG_NEEDLE_LENGTH = 2'd2,
        CFG_SEARCH_LAST   = 2'd3
    } t_cfg_idx;

    // One accepted haystack byte, as seen by the run tracker.
    typedef struct packed {
        logic shift;
        logic last;
        logic hit;
    } t_step;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ssfl_hay_if.sv
// Haystack request channel: one byte and an end-of-haystack mark.
// Depends on ssfl_pkg.
`default_nettype none

interface ssfl_hay_if;
    logic                        valid;
    logic                        ready;
    logic [ssfl_pkg::BYTE_W-1:0] hay_byte;
    logic                        last_byte;

    modport source (output valid, output hay_byte, output last_byte, input ready);
    modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/ssfl_res_if.sv
// Result channel: found flag, match offset and overflow flag.
// Depends on ssfl_pkg.
`default_nettype none

interface ssfl_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [ssfl_pkg::POS_W-1:0] position;
    logic                       overflow;

    modport source (output valid, output found, output position, output overflow,
                    input ready);
    modport sink   (input valid, input found, input position, input overflow,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ssfl_cell.sv
// One window cell: holds a haystack byte, passes it on, and extends the match chain.
// Depends on ssfl_pkg.
`default_nettype none

module ssfl_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_shift,
    input  wire logic [ssfl_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [ssfl_pkg::BYTE_W-1:0] i_pattern,
    input  wire logic                        i_active,
    input  wire logic                        i_match,
    output      logic [ssfl_pkg::BYTE_W-1:0] o_byte,
    output      logic                        o_match
);

    logic [ssfl_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // Compare the byte this cell takes on now, so the hit covers the new window.
    assign o_match = i_match & (~i_active | (i_byte == i_pattern));
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

FILE: rtl/ssfl_track.sv
// Run tracker: saturating byte count, first and last match offsets, result build.
// Depends on ssfl_pkg.
`default_nettype none

module ssfl_track #(
    parameter int HAY_MAX = 65536,
    parameter int LEN_W   = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ssfl_pkg::t_step   i_step,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire logic              i_search_last,
    output      logic              o_res_valid,
    output      ssfl_pkg::t_result o_res
);

    localparam int CNT_W = $clog2(HAY_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HAY_MAX);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_first, n_first;
    logic [CNT_W-1:0] r_last, n_last;
    logic             r_seen, n_seen;
    logic             r_sat, n_sat;

    logic                          counted;
    logic                          hit;
    logic [CNT_W-1:0]              len_ext;
    logic [CNT_W-1:0]              start;
    logic [CNT_W-1:0]              pos_sel;
    logic [CNT_W+ssfl_pkg::POS_W-1:0] pos_wide;

    assign len_ext = {{(CNT_W-LEN_W){1'b0}}, i_len};

    always_comb begin
        counted = (r_cnt < CNT_MAX);
        n_cnt   = counted ? (r_cnt + 1'b1) : r_cnt;
        n_sat   = r_sat | ~counted;
        hit     = counted && (i_len != '0) && (n_cnt >= len_ext) && i_step.hit;
        start   = n_cnt - len_ext;
        n_first = (hit && !r_seen) ? start : r_first;
        n_last  = hit ? start : r_last;
        n_seen  = r_seen | hit;

        // Empty needle: offset 0 in first mode, haystack length in last mode.
        if (i_len == '0) begin
            pos_sel = i_search_last ? n_cnt : '0;
        end else if (n_seen) begin
            pos_sel = i_search_last ? n_last : n_first;
        end else begin
            pos_sel = '0;
        end
        pos_wide = {{ssfl_pkg::POS_W{1'b0}}, pos_sel};

        o_res_valid     = i_step.shift & i_step.last;
        o_res.found     = (i_len == '0) | n_seen;
        o_res.position  = pos_wide[ssfl_pkg::POS_W-1:0];
        o_res.overflow  = n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_seen  <= 1'b0;
            r_sat   <= 1'b0;
        end else if (i_step.shift) begin
            if (i_step.last) begin
                r_cnt   <= '0;
                r_first <= '0;
                r_last  <= '0;
                r_seen  <= 1'b0;
                r_sat   <= 1'b0;
            end else begin
                r_cnt   <= n_cnt;
                r_first <= n_first;
                r_last  <= n_last;
                r_seen  <= n_seen;
                r_sat   <= n_sat;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/substring_search_first_last_unit.sv
// Streaming substring search over a byte haystack.
//
// Configure the needle through the write port (needle_low, needle_high,
// needle_length, search_last) while no haystack is in flight. Haystack bytes
// arrive on i_hay, one request per byte, with last_byte marking the final byte.
// Exactly one result is produced per haystack, on o_res, for the final byte:
// found, the first or last match offset, and an overflow flag when the byte
// count saturated at HAY_MAX.
// Throughput: one byte per cycle while input is not held off. The window of
// NEEDLE_MAX cells shifts and compares in the same cycle the byte is taken,
// so the result is valid on the cycle after the final byte is accepted.
// The result sits in an output register; i_hay.ready stays high while that
// register is empty or being drained, so a new haystack may start straight
// away. If the receiver stalls with a result held, input is held off until
// the result is taken. Reset clears the needle registers, the run state and
// the output valid flag; no clearing pass is needed.
`default_nettype none

`include "substring_search_first_last_unit_defines.svh"

module substring_search_first_last_unit #(
    parameter int NEEDLE_MAX = 16,
    parameter int HAY_MAX    = 65536
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ssfl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ssfl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ssfl_hay_if.sink                              i_hay,
    ssfl_res_if.source                            o_res
);

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int BW    = ssfl_pkg::BYTE_W;
    localparam logic [LEN_W+ssfl_pkg::NLEN_W-1:0] LEN_CAP =
        (LEN_W + ssfl_pkg::NLEN_W)'(NEEDLE_MAX);

    // Configuration registers
    logic [ssfl_pkg::CFG_DATA_W-1:0] r_needle_low;
    logic [ssfl_pkg::CFG_DATA_W-1:0] r_needle_high;
    logic [ssfl_pkg::NLEN_W-1:0]     r_needle_len;
    logic                            r_search_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low  <= '0;
            r_needle_high <= '0;
            r_needle_len  <= '0;
            r_search_last <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (ssfl_pkg::t_cfg_idx'(i_cfg_idx))
                ssfl_pkg::CFG_NEEDLE_LOW:    r_needle_low  <= i_cfg_data;
                ssfl_pkg::CFG_NEEDLE_HIGH:   r_needle_high <= i_cfg_data;
                ssfl_pkg::CFG_NEEDLE_LENGTH: r_needle_len  <= i_cfg_data[ssfl_pkg::NLEN_W-1:0];
                ssfl_pkg::CFG_SEARCH_LAST:   r_search_last <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Active length, clamped to the window size
    logic [LEN_W+ssfl_pkg::NLEN_W-1:0] len_wide;
    logic [LEN_W-1:0]                  act_len;
    logic [LEN_W-1:0]                  shamt;

    always_comb begin
        len_wide = {{LEN_W{1'b0}}, r_needle_len};
        if (len_wide > LEN_CAP) begin
            len_wide = LEN_CAP;
        end
    end
    assign act_len = len_wide[LEN_W-1:0];
    assign shamt   = LEN_W'(NEEDLE_MAX) - act_len;

    // Needle reversed byte-wise, then shifted so cell k sees needle[len-1-k].
    logic [2*ssfl_pkg::CFG_DATA_W-1:0] needle_all;
    logic [BW*NEEDLE_MAX-1:0]          needle_rev;
    logic [BW*NEEDLE_MAX-1:0]          pattern;
    logic [NEEDLE_MAX-1:0]             active;

    assign needle_all = {r_needle_high, r_needle_low};

    for (genvar m = 0; m < NEEDLE_MAX; m++) begin : g_rev
        if ((NEEDLE_MAX - 1 - m) < ssfl_pkg::NEEDLE_BYTES) begin : g_byte
            assign needle_rev[BW*m +: BW] = needle_all[BW*(NEEDLE_MAX-1-m) +: BW];
        end else begin : g_zero
            assign needle_rev[BW*m +: BW] = '0;
        end
        assign active[m] = (act_len > LEN_W'(m));
    end

    assign pattern = needle_rev >> {shamt, 3'b000};

    // Handshake and window chain
    logic r_out_valid;
    ssfl_pkg::t_result r_res;
    logic acc;

    assign i_hay.ready = ~r_out_valid | o_res.ready;
    assign acc         = i_hay.valid & i_hay.ready;

    logic [BW-1:0]       win_byte [NEEDLE_MAX];
    logic [NEEDLE_MAX:0] match;

    assign win_byte[0] = i_hay.hay_byte;
    assign match[0]    = 1'b1;

    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
        if (k < NEEDLE_MAX - 1) begin : g_mid
            ssfl_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (acc),
                .i_byte    (win_byte[k]),
                .i_pattern (pattern[BW*k +: BW]),
                .i_active  (active[k]),
                .i_match   (match[k]),
                .o_byte    (win_byte[k+1]),
                .o_match   (match[k+1])
            );
        end else begin : g_end
            // Oldest byte is never compared again.
            ssfl_cell u_cell (
                .i_clk     (i_clk),
                .i_shift   (acc),
                .i_byte    (win_byte[k]),
                .i_pattern (pattern[BW*k +: BW]),
                .i_active  (active[k]),
                .i_match   (match[k]),
                .o_byte    (),
                .o_match   (match[k+1])
            );
        end
    end

    // Run tracking
    ssfl_pkg::t_step   step;
    ssfl_pkg::t_result trk_res;
    logic              trk_valid;

    assign step.shift = acc;
    assign step.last  = i_hay.last_byte;
    assign step.hit   = match[NEEDLE_MAX];

    ssfl_track #(
        .HAY_MAX (HAY_MAX),
        .LEN_W   (LEN_W)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_len         (act_len),
        .i_search_last (r_search_last),
        .o_res_valid   (trk_valid),
        .o_res         (trk_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (trk_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (trk_valid) begin
            r_res <= trk_res;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_res.found;
    assign o_res.position = r_res.position;
    assign o_res.overflow = r_res.overflow;

    `SSFL_ASSERT_NEXT(a_last_gives_result, acc && i_hay.last_byte, o_res.valid,
                      "final byte accepted but no result held")
    `SSFL_ASSERT_NOW(a_miss_at_zero, o_res.valid && !o_res.found, o_res.position == '0,
                     "not-found result with nonzero position")
    `SSFL_ASSERT_NOW(a_empty_first, o_res.valid && (act_len == '0) && !r_search_last,
                     o_res.found && (o_res.position == '0),
                     "empty needle in first mode must report offset zero")
    `SSFL_ASSERT_NEXT(a_mid_no_result, acc && !i_hay.last_byte && !r_out_valid,
                      !o_res.valid, "result appeared for a non-final byte")

endmodule

`default_nettype wire
